/* sv/assert_macros.svh */
// Assertion macros shared by the framebuffer RTL.
// Included by every file that asserts; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framebuffer assertion failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framebuffer assertion failed");

`endif

/* sv/pfb_pkg.sv */
// Package for the paged monochrome framebuffer: sizes, reset values,
// function codes and controller states. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pfb_pkg;

    localparam int DEF_PAGES   = 8;
    localparam int DEF_COLUMNS = 128;

    localparam logic [7:0] SPAN_CLEAN = 8'hFF;
    localparam logic [7:0] RST_WIDTH  = 8'd128;
    localparam logic [6:0] RST_HEIGHT = 7'd64;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        FN_SET_PIXEL   = 3'd0,
        FN_WRITE_BYTE  = 3'd1,
        FN_CLEAR_DIRTY = 3'd2,
        FN_MARK_ALL    = 3'd3,
        FN_QUERY_SPAN  = 3'd4,
        FN_CLEAR_BUF   = 3'd5,
        FN_READ_BYTE   = 3'd6
    } func_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_WLAST,
        ST_FIN
    } state_t;

    // Row-major byte address: page * columns + column
    function automatic logic [10:0] byte_index(input logic [2:0] page,
                                               input logic [7:0] cols,
                                               input logic [7:0] col);
        return 11'(11'(page) * 11'(cols)) + 11'(col);
    endfunction

endpackage

`default_nettype wire

/* sv/pfb_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/paged_mono_framebuffer_dirty_span.sv */
// Timing: a beat is latched and its frame RAM byte read when taken in IDLE; in EXEC the
//   byte is merged and written back and the result registered once the output is free.
// No new beat is taken meanwhile; clear buffer first walks the frame RAM one byte a cycle.
// Reset: asynchronous, active low; then a clearing pass zeroes all PAGES*COLUMNS bytes
//   of the frame RAM (1024 at defaults), with input stalled; config is taken.
// Depends on pfb_pkg, pfb_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module paged_mono_framebuffer_dirty_span #(
    parameter int PAGES   = pfb_pkg::DEF_PAGES,
    parameter int COLUMNS = pfb_pkg::DEF_COLUMNS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    func,
    input  wire logic signed [10:0]            coord_x,
    input  wire logic signed [10:0]            coord_y,
    input  wire logic [2:0]                    page_index,
    input  wire logic [7:0]                    data_byte,
    input  wire logic [7:0]                    bit_mask,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               changed,
    output logic [7:0]                         dirty_mask,
    output logic                               span_found,
    output logic [7:0]                         span_first,
    output logic [7:0]                         span_last,
    output logic [7:0]                         byte_out,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data
);

    localparam int DEPTH  = PAGES * COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;

    pfb_pkg::state_t state_reg, state_next;

    // configuration
    logic [7:0] width_reg;
    logic [6:0] height_reg;

    // latched operation
    pfb_pkg::func_t    func_reg;
    logic              op_ok_reg;
    logic [2:0]        op_page_reg;
    logic [7:0]        op_col_reg;
    logic [7:0]        op_mask_reg;
    logic [7:0]        op_val_reg;
    logic [ADDR_W-1:0] op_addr_reg;

    // dirty tracking
    logic [PAGES-1:0] dirty_reg, dirty_next;
    logic [7:0]       span_low_reg  [PAGES];
    logic [7:0]       span_low_next [PAGES];
    logic [7:0]       span_high_reg [PAGES];
    logic [7:0]       span_high_next[PAGES];

    // reset clearing pass and clear-buffer walk
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] walk_addr_reg;
    logic [2:0]        walk_page_reg;
    logic [7:0]        walk_col_reg;
    logic              s_valid_reg;
    logic [ADDR_W-1:0] s_addr_reg;
    logic [2:0]        s_page_reg;
    logic [7:0]        s_col_reg;

    // output register
    logic       out_valid_reg;
    logic       changed_reg;
    logic [7:0] dirty_mask_reg;
    logic       span_found_reg;
    logic [7:0] span_first_reg;
    logic [7:0] span_last_reg;
    logic [7:0] byte_out_reg;

    // RAM ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    pfb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Geometry checks
    logic [7:0] height_sum;
    logic [4:0] pages_w;
    logic       geo_ok;
    assign height_sum = {1'b0, height_reg} + 8'd7;
    assign pages_w    = height_sum[7:3];
    assign geo_ok     = (width_reg != 8'd0) && (width_reg <= 8'(COLUMNS)) &&
                        (height_reg != 7'd0) && (pages_w <= 5'(PAGES));

    // Decode of the incoming beat
    logic              x_in, y_in, pg_ok;
    logic              acc_ok;
    logic [2:0]        acc_page;
    logic [7:0]        acc_mask, acc_val;
    logic [ADDR_W-1:0] acc_addr;
    logic [10:0]       acc_index;

    assign x_in  = !coord_x[10] && (unsigned'(coord_x) < {3'b000, width_reg});
    assign y_in  = !coord_y[10] && (unsigned'(coord_y) < {4'b0000, height_reg});
    assign pg_ok = ({2'b00, page_index} < pages_w) && ({1'b0, page_index} < 4'(PAGES));

    always_comb
    begin
        acc_ok   = geo_ok;
        acc_page = page_index;
        acc_mask = bit_mask;
        acc_val  = data_byte;
        case (func)
            pfb_pkg::FN_SET_PIXEL:
            begin
                acc_ok   = geo_ok && x_in && y_in;
                acc_page = coord_y[5:3];
                acc_mask = 8'd1 << coord_y[2:0];
                acc_val  = (data_byte != 8'd0) ? acc_mask : 8'd0;
            end
            pfb_pkg::FN_WRITE_BYTE:  acc_ok = geo_ok && x_in && pg_ok && (bit_mask != 8'd0);
            pfb_pkg::FN_READ_BYTE:   acc_ok = geo_ok && x_in && pg_ok;
            pfb_pkg::FN_QUERY_SPAN:  acc_ok = geo_ok && pg_ok;
            pfb_pkg::FN_CLEAR_DIRTY: acc_ok = 1'b1;
            default:                 acc_ok = geo_ok;
        endcase
    end

    assign acc_index = pfb_pkg::byte_index(acc_page, width_reg, coord_x[7:0]);
    assign acc_addr  = acc_index[ADDR_W-1:0];

    // Execute stage: merge the byte, look up the span
    logic              out_free;
    logic              is_write, is_clear_buf;
    logic [7:0]        merged;
    logic              wr_changed;
    logic [PG_W-1:0]   sp_idx;
    logic [7:0]        sp_low, sp_high;
    logic              found;

    assign out_free     = !out_valid_reg || !out_stall;
    assign is_write     = (func_reg == pfb_pkg::FN_SET_PIXEL) ||
                          (func_reg == pfb_pkg::FN_WRITE_BYTE);
    assign is_clear_buf = (func_reg == pfb_pkg::FN_CLEAR_BUF) && op_ok_reg;
    assign merged       = (ram_rdata & ~op_mask_reg) | (op_val_reg & op_mask_reg);
    assign wr_changed   = is_write && op_ok_reg && (merged != ram_rdata);
    assign sp_idx       = op_page_reg[PG_W-1:0];
    assign sp_low       = span_low_reg[sp_idx];
    assign sp_high      = span_high_reg[sp_idx];
    assign found        = (func_reg == pfb_pkg::FN_QUERY_SPAN) && op_ok_reg &&
                          dirty_reg[sp_idx] && (sp_low != pfb_pkg::SPAN_CLEAN) &&
                          (sp_low <= sp_high) && (sp_high < width_reg);

    // Walk progress
    logic walk_col_end, walk_last;
    assign walk_col_end = (walk_col_reg == width_reg - 8'd1);
    assign walk_last    = walk_col_end && ({2'b00, walk_page_reg} == pages_w - 5'd1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfb_pkg::ST_INIT:
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) state_next = pfb_pkg::ST_IDLE;
            pfb_pkg::ST_IDLE:
                if (in_valid) state_next = pfb_pkg::ST_EXEC;
            pfb_pkg::ST_EXEC:
                if (is_clear_buf) state_next = pfb_pkg::ST_WALK;
                else if (out_free) state_next = pfb_pkg::ST_IDLE;
            pfb_pkg::ST_WALK:
                if (walk_last) state_next = pfb_pkg::ST_WLAST;
            pfb_pkg::ST_WLAST:
                state_next = pfb_pkg::ST_FIN;
            pfb_pkg::ST_FIN:
                if (out_free) state_next = pfb_pkg::ST_IDLE;
            default:
                state_next = pfb_pkg::ST_INIT;
        endcase
    end

    // Controller outputs
    logic exec_commit, load_exec, load_fin, walk_hit;
    always_comb
    begin
        in_stall    = 1'b1;
        exec_commit = 1'b0;
        load_exec   = 1'b0;
        load_fin    = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = walk_addr_reg;
        case (state_reg)
            pfb_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                ram_re    = in_valid;
                ram_raddr = acc_addr;
            end
            pfb_pkg::ST_EXEC:
            begin
                exec_commit = out_free && !is_clear_buf;
                load_exec   = exec_commit;
            end
            pfb_pkg::ST_WALK: ram_re   = 1'b1;
            pfb_pkg::ST_FIN:  load_fin = out_free;
            default:          in_stall = 1'b1;
        endcase
    end

    assign walk_hit  = s_valid_reg && (ram_rdata != 8'd0);
    assign cfg_ready = 1'b1;

    // RAM write port: clearing pass, merged byte, or walk zeroing
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = op_addr_reg;
        ram_wdata = merged;
        if (state_reg == pfb_pkg::ST_INIT)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = 8'd0;
        end
        else if (exec_commit && wr_changed)
        begin
            ram_we = 1'b1;
        end
        else if (walk_hit)
        begin
            ram_we    = 1'b1;
            ram_waddr = s_addr_reg;
            ram_wdata = 8'd0;
        end
    end

    // Dirty bits and spans
    logic            mark_en;
    logic [2:0]      mark_page;
    logic [7:0]      mark_col;
    logic [PG_W-1:0] mark_idx;
    assign mark_en   = (exec_commit && wr_changed) || walk_hit;
    assign mark_page = walk_hit ? s_page_reg : op_page_reg;
    assign mark_col  = walk_hit ? s_col_reg : op_col_reg;
    assign mark_idx  = mark_page[PG_W-1:0];

    always_comb
    begin
        dirty_next     = dirty_reg;
        span_low_next  = span_low_reg;
        span_high_next = span_high_reg;
        if (mark_en && ({1'b0, mark_page} < 4'(PAGES)))
        begin
            if (!dirty_reg[mark_idx])
            begin
                span_low_next[mark_idx]  = mark_col;
                span_high_next[mark_idx] = mark_col;
                dirty_next[mark_idx]     = 1'b1;
            end
            else
            begin
                if (mark_col < span_low_reg[mark_idx])  span_low_next[mark_idx]  = mark_col;
                if (mark_col > span_high_reg[mark_idx]) span_high_next[mark_idx] = mark_col;
            end
        end
        else if (exec_commit && (func_reg == pfb_pkg::FN_CLEAR_DIRTY))
        begin
            for (int p = 0; p < PAGES; p++)
            begin
                if (op_mask_reg[p])
                begin
                    dirty_next[p]     = 1'b0;
                    span_low_next[p]  = pfb_pkg::SPAN_CLEAN;
                    span_high_next[p] = 8'd0;
                end
            end
        end
        else if (exec_commit && (func_reg == pfb_pkg::FN_MARK_ALL) && op_ok_reg)
        begin
            for (int p = 0; p < PAGES; p++)
            begin
                if (5'(p) < pages_w)
                begin
                    dirty_next[p]     = 1'b1;
                    span_low_next[p]  = 8'd0;
                    span_high_next[p] = width_reg - 8'd1;
                end
                else
                begin
                    dirty_next[p]     = 1'b0;
                    span_low_next[p]  = pfb_pkg::SPAN_CLEAN;
                    span_high_next[p] = 8'd0;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfb_pkg::ST_INIT;
            width_reg     <= pfb_pkg::RST_WIDTH;
            height_reg    <= pfb_pkg::RST_HEIGHT;
            clr_addr_reg  <= '0;
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            dirty_reg     <= '0;
            for (int p = 0; p < PAGES; p++)
            begin
                span_low_reg[p]  <= pfb_pkg::SPAN_CLEAN;
                span_high_reg[p] <= 8'd0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            dirty_reg      <= dirty_next;
            span_low_reg   <= span_low_next;
            span_high_reg  <= span_high_next;
            s_valid_reg    <= (state_reg == pfb_pkg::ST_WALK);
            if (state_reg == pfb_pkg::ST_INIT) clr_addr_reg <= clr_addr_reg + 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == pfb_pkg::REG_ACTIVE_WIDTH)  width_reg  <= cfg_data;
                if (cfg_index == pfb_pkg::REG_ACTIVE_HEIGHT) height_reg <= cfg_data[6:0];
            end
            if (load_exec || load_fin) out_valid_reg <= 1'b1;
            else if (!out_stall)       out_valid_reg <= 1'b0;
        end
    end

    // Operation latch, walk counters and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == pfb_pkg::ST_IDLE && in_valid)
        begin
            func_reg    <= pfb_pkg::func_t'(func);
            op_ok_reg   <= acc_ok;
            op_page_reg <= acc_page;
            op_col_reg  <= coord_x[7:0];
            op_mask_reg <= acc_mask;
            op_val_reg  <= acc_val;
            op_addr_reg <= acc_addr;
        end
        if (state_reg == pfb_pkg::ST_EXEC)
        begin
            walk_addr_reg <= '0;
            walk_page_reg <= 3'd0;
            walk_col_reg  <= 8'd0;
        end
        else if (state_reg == pfb_pkg::ST_WALK)
        begin
            walk_addr_reg <= walk_addr_reg + 1'b1;
            if (walk_col_end)
            begin
                walk_col_reg  <= 8'd0;
                walk_page_reg <= walk_page_reg + 3'd1;
            end
            else
            begin
                walk_col_reg <= walk_col_reg + 8'd1;
            end
        end
        s_addr_reg <= walk_addr_reg;
        s_page_reg <= walk_page_reg;
        s_col_reg  <= walk_col_reg;
        if (load_exec || load_fin)
        begin
            changed_reg    <= load_exec && wr_changed;
            dirty_mask_reg <= 8'(dirty_next);
            span_found_reg <= load_exec && found;
            span_first_reg <= (load_exec && found) ? sp_low : 8'd0;
            span_last_reg  <= (load_exec && found) ? sp_high : 8'd0;
            byte_out_reg   <= (load_exec && (func_reg == pfb_pkg::FN_READ_BYTE) && op_ok_reg)
                              ? ram_rdata : 8'd0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign changed    = changed_reg;
    assign dirty_mask = dirty_mask_reg;
    assign span_found = span_found_reg;
    assign span_first = span_first_reg;
    assign span_last  = span_last_reg;
    assign byte_out   = byte_out_reg;

    // Checks
    `ASSERT_SAME(a_accept_idle, clk, rst_n, !in_stall, state_reg == pfb_pkg::ST_IDLE)
    `ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && !in_stall, state_reg == pfb_pkg::ST_EXEC)
    `ASSERT_SAME(a_no_write_idle, clk, rst_n, state_reg == pfb_pkg::ST_IDLE, !ram_we)
    `ASSERT_SAME(a_init_no_out, clk, rst_n, state_reg == pfb_pkg::ST_INIT, !out_valid_reg)
    `ASSERT_SAME(a_span_order, clk, rst_n, out_valid_reg && span_found_reg,
                 span_first_reg <= span_last_reg)

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for paged_mono_framebuffer_dirty_span: directed and random
// beats under random idling, with a shadow framebuffer that predicts every result in order.
// Depends on pfb_pkg and the framebuffer RTL.

module tb;

    localparam int NUM_PAGES      = 8;
    localparam int NUM_COLS       = 128;
    localparam int STORE_BYTES    = NUM_PAGES * NUM_COLS;
    localparam logic [2:0] FN_NONE = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic       changed;
        logic [7:0] dirty_mask;
        logic       span_found;
        logic [7:0] span_first;
        logic [7:0] span_last;
        logic [7:0] byte_out;
    } fb_result_t;

    // Shadow copy of the framebuffer state plus the queue of predicted results
    class frame_shadow;
        logic [7:0]  store [STORE_BYTES];
        logic [7:0]  dirty;
        logic [7:0]  lo_col [NUM_PAGES];
        logic [7:0]  hi_col [NUM_PAGES];
        int unsigned width;
        int unsigned height;
        fb_result_t  pending_results [$];
        int          mismatch_count;

        function new();
            for (int i = 0; i < STORE_BYTES; i++)
                store[i] = 8'h00;
            dirty = 8'h00;
            for (int p = 0; p < NUM_PAGES; p++)
            begin
                lo_col[p] = pfb_pkg::SPAN_CLEAN;
                hi_col[p] = 8'h00;
            end
            width = pfb_pkg::RST_WIDTH;
            height = pfb_pkg::RST_HEIGHT;
            mismatch_count = 0;
        endfunction

        function int unsigned page_count();
            return (height + 7) / 8;
        endfunction

        function bit geom_ok();
            return width != 0 && width <= NUM_COLS && height != 0 &&
                   page_count() <= NUM_PAGES;
        endfunction

        function void clean_page(int unsigned page);
            lo_col[page] = pfb_pkg::SPAN_CLEAN;
            hi_col[page] = 8'h00;
        endfunction

        // Widen the page's dirty span to cover column x
        function void mark_col(int unsigned page, int unsigned x);
            if (page >= NUM_PAGES || x >= width)
                return;
            if (!dirty[page])
            begin
                lo_col[page] = 8'(x);
                hi_col[page] = 8'(x);
                dirty[page] = 1'b1;
                return;
            end
            if (x < lo_col[page])
                lo_col[page] = 8'(x);
            if (x > hi_col[page])
                hi_col[page] = 8'(x);
        endfunction

        // Read-modify-write of one byte; true when the byte changed
        function bit write_masked(int unsigned page, int unsigned x,
                                  logic [7:0] value, logic [7:0] mask);
            int unsigned idx;
            logic [7:0] nv;
            if (!geom_ok() || page >= page_count() || page >= NUM_PAGES ||
                x >= width || mask == 8'h00)
                return 1'b0;
            idx = page * width + x;
            if (idx >= STORE_BYTES)
                return 1'b0;
            nv = (store[idx] & ~mask) | (value & mask);
            if (nv == store[idx])
                return 1'b0;
            store[idx] = nv;
            mark_col(page, x);
            return 1'b1;
        endfunction

        function void configure(logic [pfb_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == pfb_pkg::REG_ACTIVE_WIDTH)
                width = data;
            else
                height = data[6:0];
        endfunction

        // Apply one accepted input beat and queue the result it should produce
        function void predict_beat(logic [2:0] fn, logic [10:0] x, logic [10:0] y,
                                   logic [2:0] page, logic [7:0] data, logic [7:0] mask);
            fb_result_t r;
            int unsigned xu, yu, pg, npages, idx;
            logic [7:0] bitm;
            r = '0;
            xu = x;
            yu = y;
            pg = page;
            case (fn)
                pfb_pkg::FN_SET_PIXEL:
                    if (geom_ok() && !x[10] && !y[10] && xu < width && yu < height)
                    begin
                        bitm = 8'h01 << (yu % 8);
                        r.changed = write_masked(yu / 8, xu,
                                                 (data != 8'h00) ? bitm : 8'h00, bitm);
                    end
                pfb_pkg::FN_WRITE_BYTE:
                    if (!x[10])
                        r.changed = write_masked(pg, xu, data, mask);
                pfb_pkg::FN_CLEAR_DIRTY:
                begin
                    dirty &= ~mask;
                    for (int p = 0; p < NUM_PAGES; p++)
                        if (mask[p])
                            clean_page(p);
                end
                pfb_pkg::FN_MARK_ALL:
                    if (geom_ok())
                    begin
                        npages = page_count();
                        dirty = (npages >= 8) ? 8'hFF : 8'((1 << npages) - 1);
                        for (int p = 0; p < NUM_PAGES; p++)
                        begin
                            if (p < npages)
                            begin
                                lo_col[p] = 8'h00;
                                hi_col[p] = 8'(width - 1);
                            end
                            else
                                clean_page(p);
                        end
                    end
                pfb_pkg::FN_QUERY_SPAN:
                    if (geom_ok() && pg < page_count() && pg < NUM_PAGES && dirty[pg] &&
                        lo_col[pg] != pfb_pkg::SPAN_CLEAN && lo_col[pg] <= hi_col[pg] &&
                        hi_col[pg] < width)
                    begin
                        r.span_found = 1'b1;
                        r.span_first = lo_col[pg];
                        r.span_last = hi_col[pg];
                    end
                pfb_pkg::FN_CLEAR_BUF:
                    if (geom_ok())
                    begin
                        npages = page_count();
                        for (int p = 0; p < npages; p++)
                            for (int c = 0; c < width; c++)
                                void'(write_masked(p, c, 8'h00, 8'hFF));
                    end
                pfb_pkg::FN_READ_BYTE:
                    if (geom_ok() && !x[10] && xu < width && pg < page_count() &&
                        pg < NUM_PAGES)
                    begin
                        idx = pg * width + xu;
                        if (idx < STORE_BYTES)
                            r.byte_out = store[idx];
                    end
                default: ;
            endcase
            r.dirty_mask = dirty;
            pending_results.push_back(r);
        endfunction

        // Compare one accepted result beat against the oldest prediction
        function void compare_beat(fb_result_t got);
            fb_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("extra beat: chg=%0d dm=%h fnd=%0d first=%0d last=%0d byte=%h",
                             got.changed, got.dirty_mask, got.span_found,
                             got.span_first, got.span_last, got.byte_out);
                return;
            end
            want = pending_results.pop_front();
            if (got.changed !== want.changed || got.dirty_mask !== want.dirty_mask ||
                got.span_found !== want.span_found || got.span_first !== want.span_first ||
                got.span_last !== want.span_last || got.byte_out !== want.byte_out)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("expected: chg=%0d dm=%h fnd=%0d first=%0d last=%0d byte=%h",
                             want.changed, want.dirty_mask, want.span_found,
                             want.span_first, want.span_last, want.byte_out);
                    $display("actual:   chg=%0d dm=%h fnd=%0d first=%0d last=%0d byte=%h",
                             got.changed, got.dirty_mask, got.span_found,
                             got.span_first, got.span_last, got.byte_out);
                end
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [2:0]                    func = 3'd0;
    logic [10:0]                   coord_x = 11'd0;
    logic [10:0]                   coord_y = 11'd0;
    logic [2:0]                    page_index = 3'd0;
    logic [7:0]                    data_byte = 8'd0;
    logic [7:0]                    bit_mask = 8'd0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          changed;
    logic [7:0]                    dirty_mask;
    logic                          span_found;
    logic [7:0]                    span_first;
    logic [7:0]                    span_last;
    logic [7:0]                    byte_out;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [pfb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]                    cfg_data = 8'd0;

    frame_shadow shadow;
    bit tx_noisy = 1'b0;
    bit idle_off = 1'b0;

    paged_mono_framebuffer_dirty_span dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .page_index (page_index),
        .data_byte  (data_byte),
        .bit_mask   (bit_mask),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .changed    (changed),
        .dirty_mask (dirty_mask),
        .span_found (span_found),
        .span_first (span_first),
        .span_last  (span_last),
        .byte_out   (byte_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // Result-side stall: random bursts during noisy stretches
    int stall_left = 0;
    int stretch_left = 0;
    bit rx_noisy = 1'b0;
    always @(posedge clk)
    begin
        if (stretch_left == 0)
        begin
            rx_noisy = ($urandom_range(0, 2) != 0);
            stretch_left = $urandom_range(50, 400);
        end
        else
            stretch_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!idle_off && rx_noisy && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 18);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Result monitor
    always @(posedge clk)
    begin : result_monitor
        fb_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{changed, dirty_mask, span_found, span_first, span_last, byte_out};
            shadow.compare_beat(got);
        end
    end

    // Watchdog on cycles with no beat moving on any channel
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (rst_n)
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Drive one input beat, holding it until accepted
    task automatic send_beat(input logic [2:0] fn, input logic [10:0] x, input logic [10:0] y,
                             input logic [2:0] pg, input logic [7:0] data,
                             input logic [7:0] mask);
        if (!idle_off && tx_noisy && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        coord_x <= x;
        coord_y <= y;
        page_index <= pg;
        data_byte <= data;
        bit_mask <= mask;
        do @(posedge clk); while (in_stall);
        shadow.predict_beat(fn, x, y, pg, data, mask);
    endtask

    // Stop sending and wait for every predicted result, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (shadow.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Both geometry registers, written back to back on an idle block
    task automatic set_geometry(input logic [7:0] w, input logic [7:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= pfb_pkg::REG_ACTIVE_WIDTH;
        cfg_data <= w;
        do @(posedge clk); while (!cfg_ready);
        shadow.configure(pfb_pkg::REG_ACTIVE_WIDTH, w);
        cfg_index <= pfb_pkg::REG_ACTIVE_HEIGHT;
        cfg_data <= h;
        do @(posedge clk); while (!cfg_ready);
        shadow.configure(pfb_pkg::REG_ACTIVE_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // One random beat, biased toward in-range coordinates and their edges
    task automatic random_beat();
        int r;
        int unsigned npg;
        logic [2:0] fn;
        logic [10:0] x, y;
        logic [2:0] pg;
        logic [7:0] data, mask;
        r = $urandom_range(0, 99);
        if (r < 30)      fn = pfb_pkg::FN_SET_PIXEL;
        else if (r < 55) fn = pfb_pkg::FN_WRITE_BYTE;
        else if (r < 62) fn = pfb_pkg::FN_CLEAR_DIRTY;
        else if (r < 65) fn = pfb_pkg::FN_MARK_ALL;
        else if (r < 77) fn = pfb_pkg::FN_QUERY_SPAN;
        else if (r < 79) fn = pfb_pkg::FN_CLEAR_BUF;
        else if (r < 97) fn = pfb_pkg::FN_READ_BYTE;
        else             fn = FN_NONE;

        r = $urandom_range(0, 9);
        if (r == 0)      x = 11'($urandom);
        else if (r == 1) x = 11'(int'(shadow.width) + int'($urandom_range(0, 2)) - 1);
        else             x = 11'($urandom_range(0, shadow.width > 0 ? shadow.width - 1 : 0));
        r = $urandom_range(0, 9);
        if (r == 0)      y = 11'($urandom);
        else if (r == 1) y = 11'(int'(shadow.height) + int'($urandom_range(0, 2)) - 1);
        else             y = 11'($urandom_range(0, shadow.height > 0 ? shadow.height - 1 : 0));

        npg = shadow.page_count();
        if (npg == 0) npg = 1;
        if (npg > NUM_PAGES) npg = NUM_PAGES;
        if ($urandom_range(0, 4) == 0) pg = 3'($urandom);
        else                           pg = 3'($urandom_range(0, npg - 1));

        data = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
        r = $urandom_range(0, 7);
        if (r == 0)      mask = 8'h00;
        else if (r == 1) mask = 8'hFF;
        else             mask = 8'($urandom);
        send_beat(fn, x, y, pg, data, mask);
    endtask

    task automatic run_phase(input logic [7:0] w, input logic [7:0] h, input int beats,
                             input bit quiet);
        set_geometry(w, h);
        idle_off = quiet;
        for (int i = 0; i < beats; i++)
        begin
            if (i % 100 == 0)
                tx_noisy = ($urandom_range(0, 2) != 0);
            random_beat();
        end
        wait_drained();
    endtask

    initial
    begin
        shadow = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats at the reset geometry (128 x 64)
        send_beat(pfb_pkg::FN_SET_PIXEL,   11'd0,    11'd0,    3'd0, 8'h01, 8'h00);
        send_beat(pfb_pkg::FN_SET_PIXEL,   11'd0,    11'd0,    3'd0, 8'h01, 8'h00);  // unchanged
        send_beat(pfb_pkg::FN_SET_PIXEL,   11'd127,  11'd63,   3'd0, 8'h80, 8'h00);
        send_beat(pfb_pkg::FN_SET_PIXEL,   11'h7FF,  11'd5,    3'd0, 8'hFF, 8'h00);  // x < 0
        send_beat(pfb_pkg::FN_SET_PIXEL,   11'd128,  11'd5,    3'd0, 8'hFF, 8'h00);  // x too big
        send_beat(pfb_pkg::FN_SET_PIXEL,   11'd5,    11'd64,   3'd0, 8'hFF, 8'h00);  // y too big
        send_beat(pfb_pkg::FN_SET_PIXEL,   11'd5,    11'h400,  3'd0, 8'hFF, 8'h00);  // min y
        send_beat(pfb_pkg::FN_SET_PIXEL,   11'h3FF,  11'd0,    3'd0, 8'hFF, 8'h00);
        send_beat(pfb_pkg::FN_WRITE_BYTE,  11'd127,  11'd0,    3'd7, 8'hFF, 8'hFF);
        send_beat(pfb_pkg::FN_WRITE_BYTE,  11'd10,   11'd0,    3'd3, 8'hAA, 8'h00);  // no mask
        send_beat(pfb_pkg::FN_WRITE_BYTE,  11'd127,  11'd0,    3'd7, 8'hFF, 8'h0F);  // unchanged
        send_beat(pfb_pkg::FN_WRITE_BYTE,  11'h7FF,  11'd0,    3'd2, 8'h55, 8'hFF);  // x < 0
        send_beat(pfb_pkg::FN_READ_BYTE,   11'd127,  11'd0,    3'd7, 8'h00, 8'h00);
        send_beat(pfb_pkg::FN_READ_BYTE,   11'd0,    11'd0,    3'd0, 8'h00, 8'h00);
        send_beat(pfb_pkg::FN_QUERY_SPAN,  11'd0,    11'd0,    3'd7, 8'h00, 8'h00);
        send_beat(pfb_pkg::FN_QUERY_SPAN,  11'd0,    11'd0,    3'd0, 8'h00, 8'h00);
        send_beat(pfb_pkg::FN_QUERY_SPAN,  11'd0,    11'd0,    3'd3, 8'h00, 8'h00);  // clean
        send_beat(pfb_pkg::FN_CLEAR_DIRTY, 11'd0,    11'd0,    3'd0, 8'h00, 8'h80);
        send_beat(pfb_pkg::FN_QUERY_SPAN,  11'd0,    11'd0,    3'd7, 8'h00, 8'h00);
        send_beat(pfb_pkg::FN_MARK_ALL,    11'd0,    11'd0,    3'd0, 8'h00, 8'h00);
        send_beat(pfb_pkg::FN_QUERY_SPAN,  11'd0,    11'd0,    3'd5, 8'h00, 8'h00);
        send_beat(pfb_pkg::FN_CLEAR_BUF,   11'd0,    11'd0,    3'd0, 8'h00, 8'h00);
        send_beat(pfb_pkg::FN_READ_BYTE,   11'd127,  11'd0,    3'd7, 8'h00, 8'h00);
        send_beat(FN_NONE,                 11'h7FF,  11'h7FF,  3'd7, 8'hFF, 8'hFF);
        send_beat(pfb_pkg::FN_SET_PIXEL,   11'd0,    11'd0,    3'd0, 8'h00, 8'h00);
        wait_drained();

        // Random phases; a narrower width right after full size leaves stale spans
        run_phase(8'd128, 8'd64,  550, 1'b0);
        run_phase(8'd20,  8'd64,  100, 1'b0);
        run_phase(8'd1,   8'd1,    60, 1'b0);
        run_phase(8'd0,   8'd64,   30, 1'b0);  // inert: no columns
        run_phase(8'd128, 8'd0,    30, 1'b0);  // inert: no rows
        run_phase(8'd255, 8'd64,   30, 1'b0);  // inert: too wide
        run_phase(8'd128, 8'd127,  30, 1'b0);  // inert: too many pages
        run_phase(8'd128, 8'd65,   30, 1'b0);  // inert: nine pages
        run_phase(8'd37,  8'd23,  200, 1'b0);
        run_phase(8'd8,   8'd9,   120, 1'b0);
        run_phase(8'd128, 8'd64,  300, 1'b1);  // closing stretch, no idling

        if (shadow.mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* paged_mono_framebuffer_dirty_span.f */
+incdir+sv
sv/pfb_pkg.sv
sv/pfb_ram.sv
sv/paged_mono_framebuffer_dirty_span.sv
tb/tb.sv
